@@ rtl/blocked_position_run_length_macros.svh @@
// Assertion macros for the blocked-position run-length block.
// Used by the port checker; no other dependencies.
`ifndef BLOCKED_POSITION_RUN_LENGTH_MACROS_SVH
`define BLOCKED_POSITION_RUN_LENGTH_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BPRL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bprl check failed");
// Next-cycle implication checked outside reset.
`define BPRL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bprl check failed");
`endif

@@ rtl/bprl_pkg.sv @@
// Package for the blocked-position run-length block.
// Holds sizes, operation codes and the controller state type.
package bprl_pkg;
    localparam int MAX_POSITIONS_DEF = 4096;
    localparam int STACK_DEPTH_DEF   = 4096;
    localparam int POS_W   = 12;
    localparam int COUNT_W = 13;
    localparam logic [1:0] OP_BLOCK   = 2'd0;
    localparam logic [1:0] OP_RESTORE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;
    localparam logic [POS_W-1:0] NUM_POS_RESET = 12'd4094;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_BRD    = 9'b000000100,
        ST_RRD    = 9'b000001000,
        ST_RCNT   = 9'b000010000,
        ST_QRD    = 9'b000100000,
        ST_QDOWN  = 9'b001000000,
        ST_QUP    = 9'b010000000,
        ST_WB     = 9'b100000000
    } state_t;
endpackage

@@ rtl/bprl_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module bprl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/blocked_position_run_length.sv @@
// Blocked-position run length: one request at a time while busy is low.
// A block updates the count entry of its position and pushes the position; a
// restore pops a position and updates its count entry; a query out of range or
// on a flagged position answers zero, and any other query scans the count entries
// below and then above the position. A query result is registered and shows on
// done as busy falls; a query out of range never raises busy. After reset a clearing
// pass zeroes the count memory; busy stays high meanwhile. The count memory (one read
// port) sets the scan rate. Results cannot be stalled.
// Depends on bprl_pkg and bprl_ram.
module blocked_position_run_length #(
    parameter int MAX_POSITIONS = bprl_pkg::MAX_POSITIONS_DEF,
    parameter int STACK_DEPTH   = bprl_pkg::STACK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  operation,
    input  logic [bprl_pkg::POS_W-1:0]  position,
    output logic                        done,
    output logic [bprl_pkg::POS_W-1:0]  run_length,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bprl_pkg::POS_W-1:0]  cfg_data
);
    localparam int AW  = $clog2(MAX_POSITIONS);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int PW  = bprl_pkg::POS_W;
    localparam int CW  = bprl_pkg::COUNT_W;
    localparam int SPW = SW + 1;
    // widened position for compares
    localparam int XW  = (AW > PW ? AW : PW) + 1;

    bprl_pkg::state_t state_reg, state_next;
    logic [PW-1:0]  num_reg;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [XW-1:0]  scan_reg, scan_next;
    logic [XW-1:0]  lo_reg, lo_next;
    logic [PW-1:0]  res_reg, res_next;
    logic           done_reg, done_next;

    // count memory: bit CW is the blocked flag
    logic          cm_we;
    logic [AW-1:0] cm_waddr, cm_raddr;
    logic [CW:0]   cm_wdata, cm_rdata;
    logic          st_we;
    logic [SW-1:0] st_waddr, st_raddr;
    logic [PW-1:0] st_wdata, st_rdata;

    bprl_ram #(.WIDTH(CW + 1), .DEPTH(MAX_POSITIONS)) u_cnt (
        .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
        .raddr(cm_raddr), .rdata(cm_rdata)
    );
    bprl_ram #(.WIDTH(PW), .DEPTH(STACK_DEPTH)) u_stk (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    // effective range and derived values
    logic [XW-1:0] n_eff, p_x, top_x;
    logic          cnt_nz;
    always_comb
    begin
        if (XW'(num_reg) > XW'(MAX_POSITIONS - 1))
            n_eff = XW'(MAX_POSITIONS - 1);
        else
            n_eff = XW'(num_reg);
        p_x    = XW'(pos_reg);
        top_x  = XW'(st_rdata);
        cnt_nz = (cm_rdata[CW-1:0] != '0);
    end

    assign busy       = (state_reg != bprl_pkg::ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign run_length = res_reg;

    // controller
    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        clr_next   = clr_reg;
        pos_next   = pos_reg;
        scan_next  = scan_reg;
        lo_next    = lo_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        cm_we      = 1'b0;
        cm_waddr   = AW'(pos_reg);
        cm_wdata   = cm_rdata;
        cm_raddr   = AW'(pos_reg);
        st_we      = 1'b0;
        st_waddr   = sp_reg[SW-1:0];
        st_wdata   = pos_reg;
        st_raddr   = SW'(sp_reg - SPW'(1));
        case (state_reg)
            bprl_pkg::ST_CLEAR:
            begin
                cm_we    = 1'b1;
                cm_waddr = clr_reg;
                cm_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_POSITIONS - 1))
                    state_next = bprl_pkg::ST_IDLE;
            end
            bprl_pkg::ST_IDLE:
            begin
                cm_raddr = AW'(position);
                pos_next = position;
                if (start)
                begin
                    case (operation)
                        bprl_pkg::OP_BLOCK:
                            if (position != '0 && XW'(position) <= n_eff
                                && sp_reg < SPW'(STACK_DEPTH))
                                state_next = bprl_pkg::ST_BRD;
                        bprl_pkg::OP_RESTORE:
                            if (sp_reg != '0)
                            begin
                                sp_next    = sp_reg - SPW'(1);
                                state_next = bprl_pkg::ST_RRD;
                            end
                        bprl_pkg::OP_QUERY:
                            if (position == '0 || XW'(position) > n_eff)
                            begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end
                            else
                                state_next = bprl_pkg::ST_QRD;
                        default: ;
                    endcase
                end
            end
            bprl_pkg::ST_BRD:
            begin
                // count data arrives now; write back incremented
                cm_we      = 1'b1;
                cm_wdata   = {1'b1, cm_rdata[CW-1:0] + CW'(1)};
                st_we      = 1'b1;
                sp_next    = sp_reg + SPW'(1);
                state_next = bprl_pkg::ST_IDLE;
            end
            bprl_pkg::ST_RRD:
            begin
                // stack top read in flight
                st_raddr   = sp_reg[SW-1:0];
                state_next = bprl_pkg::ST_RCNT;
            end
            bprl_pkg::ST_RCNT:
            begin
                st_raddr = sp_reg[SW-1:0];
                pos_next = st_rdata;
                cm_raddr = AW'(st_rdata);
                if (top_x < XW'(MAX_POSITIONS))
                    state_next = bprl_pkg::ST_WB;
                else
                    state_next = bprl_pkg::ST_IDLE;
            end
            bprl_pkg::ST_WB:
            begin
                cm_we = 1'b1;
                cm_wdata = {1'b0, cnt_nz ? cm_rdata[CW-1:0] - CW'(1) : cm_rdata[CW-1:0]};
                state_next = bprl_pkg::ST_IDLE;
            end
            bprl_pkg::ST_QRD:
            begin
                // flag of queried position is here
                if (cm_rdata[CW])
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = bprl_pkg::ST_IDLE;
                end
                else
                begin
                    scan_next  = p_x - XW'(1);
                    cm_raddr   = AW'(p_x - XW'(1));
                    state_next = bprl_pkg::ST_QDOWN;
                end
            end
            bprl_pkg::ST_QDOWN:
            begin
                // cm_rdata is count at scan_reg
                if (scan_reg == '0 || cnt_nz)
                begin
                    lo_next    = scan_reg;
                    scan_next  = p_x + XW'(1);
                    cm_raddr   = AW'(p_x + XW'(1));
                    state_next = bprl_pkg::ST_QUP;
                end
                else
                begin
                    scan_next = scan_reg - XW'(1);
                    cm_raddr  = AW'(scan_reg - XW'(1));
                end
            end
            bprl_pkg::ST_QUP:
            begin
                if (scan_reg > n_eff || cnt_nz)
                begin
                    res_next   = PW'(scan_reg - lo_reg - XW'(1));
                    done_next  = 1'b1;
                    state_next = bprl_pkg::ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + XW'(1);
                    cm_raddr  = AW'(scan_reg + XW'(1));
                end
            end
            default:
                state_next = bprl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bprl_pkg::ST_CLEAR;
            sp_reg    <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            num_reg   <= bprl_pkg::NUM_POS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_valid)
                num_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        scan_reg <= scan_next;
        lo_reg   <= lo_next;
        res_reg  <= res_next;
    end
endmodule

@@ rtl/bprl_checker.sv @@
// Port-level checker for the run-length block, bound to the top level.
// Depends on blocked_position_run_length_macros.svh and bprl_pkg.
`include "blocked_position_run_length_macros.svh"
module bprl_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic [1:0] operation,
    input logic done,
    input logic [11:0] run_length
);
    `BPRL_ASSERT_NEXT(a_block_quiet, start && !busy && operation != bprl_pkg::OP_QUERY, !done)
    `BPRL_ASSERT_IMPL(a_done_not_busy, done, !busy)
    `BPRL_ASSERT_IMPL(a_result_known, done, !$isunknown(run_length))
endmodule

bind blocked_position_run_length bprl_checker u_bprl_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .operation(operation), .done(done), .run_length(run_length)
);
